// ===== sv/pad_controller_midi_event_decoder_defines.svh =====
// Assertion helpers shared by the decoder RTL.
`ifndef PAD_CONTROLLER_MIDI_EVENT_DECODER_DEFINES_SVH
`define PAD_CONTROLLER_MIDI_EVENT_DECODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCMED_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PCMED_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/pcmed_pkg.sv =====
package pcmed_pkg;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_USER_W = 5;
    localparam int NUM_RANGES = 35;

    localparam logic [7:0] ST_NOTE_OFF  = 8'd128;
    localparam logic [7:0] ST_NOTE_ON   = 8'd144;
    localparam logic [7:0] ST_POLY_AT   = 8'd160;
    localparam logic [7:0] ST_CTRL      = 8'd176;
    localparam logic [7:0] ST_PITCH     = 8'd224;

    localparam logic [1:0] KIND_PRESS   = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_CHANGE  = 2'd2;

    localparam logic [1:0] DIV_ONE      = 2'd0;
    localparam logic [1:0] DIV_7BIT     = 2'd1;
    localparam logic [1:0] DIV_14BIT    = 2'd2;

    localparam logic [7:0] ID_BUTTON0   = 8'd64;
    localparam logic [7:0] ID_KNOB0     = 8'd128;
    localparam logic [7:0] ID_SLIDER    = 8'd139;
    localparam logic [6:0] NOTE_PAD_FIRST = 7'd36;
    localparam logic [6:0] ECHO_LEVEL_ON = 7'd10;

    localparam logic [6:0] CC_LO [NUM_RANGES] = '{
        7'd102, 7'd20, 7'd85, 7'd116, 7'd9, 7'd3, 7'd36,
        7'd29, 7'd28, 7'd48, 7'd50, 7'd52, 7'd54, 7'd56,
        7'd58, 7'd60, 7'd62, 7'd110, 7'd112, 7'd114, 7'd49,
        7'd51, 7'd53, 7'd55, 7'd57, 7'd59, 7'd61, 7'd63,
        7'd111, 7'd113, 7'd115, 7'd47, 7'd44, 7'd46, 7'd45
    };
    localparam logic [6:0] CC_HI [NUM_RANGES] = '{
        7'd109, 7'd27, 7'd90, 7'd119, 7'd9, 7'd3, 7'd43,
        7'd29, 7'd28, 7'd48, 7'd50, 7'd52, 7'd54, 7'd56,
        7'd58, 7'd60, 7'd62, 7'd110, 7'd112, 7'd114, 7'd49,
        7'd51, 7'd53, 7'd55, 7'd57, 7'd59, 7'd61, 7'd63,
        7'd111, 7'd113, 7'd115, 7'd47, 7'd44, 7'd46, 7'd45
    };
    localparam logic [5:0] CC_BASE [NUM_RANGES] = '{
        6'd0, 6'd8, 6'd16, 6'd22, 6'd26, 6'd27, 6'd28,
        6'd36, 6'd37, 6'd38, 6'd39, 6'd40, 6'd41, 6'd42,
        6'd43, 6'd44, 6'd45, 6'd46, 6'd47, 6'd48, 6'd49,
        6'd50, 6'd51, 6'd52, 6'd53, 6'd54, 6'd55, 6'd56,
        6'd57, 6'd58, 6'd59, 6'd60, 6'd61, 6'd62, 6'd63
    };

    typedef struct packed {
        logic       ok;
        logic [7:0] id;
    } t_map;

    function automatic t_map map_note(input logic [6:0] n);
        t_map       res;
        logic [3:0] knob;
        res = '0;
        knob = n[3:0];
        if (n == 7'd9) begin
            knob = 4'd10;
        end else if (n == 7'd10) begin
            knob = 4'd9;
        end
        if (n >= NOTE_PAD_FIRST && n < 7'd100) begin
            res.ok = 1'b1;
            res.id = {1'b0, n - NOTE_PAD_FIRST};
        end else if (n < 7'd11) begin
            res.ok = 1'b1;
            res.id = ID_KNOB0 + {4'd0, knob};
        end else if (n == 7'd12) begin
            res.ok = 1'b1;
            res.id = ID_SLIDER;
        end
        return res;
    endfunction

    function automatic t_map map_cc(input logic [6:0] c);
        t_map res;
        res = '0;
        if (c == 7'd14) begin
            res.ok = 1'b1;
            res.id = ID_KNOB0 + 8'd9;
        end else if (c == 7'd15) begin
            res.ok = 1'b1;
            res.id = ID_KNOB0 + 8'd10;
        end else if (c >= 7'd71 && c <= 7'd79) begin
            res.ok = 1'b1;
            res.id = ID_KNOB0 + {1'b0, c - 7'd71};
        end else begin
            for (int i = 0; i < NUM_RANGES; i++) begin
                if (c >= CC_LO[i] && c <= CC_HI[i]) begin
                    res.ok = 1'b1;
                    res.id = ID_BUTTON0 + {2'd0, CC_BASE[i]} + {1'b0, c - CC_LO[i]};
                end
            end
        end
        return res;
    endfunction

endpackage

// ===== sv/pad_controller_midi_event_decoder.sv =====
// Pad controller MIDI event decoder.
// The slave stream carries one three-byte MIDI message per transfer; the master
// stream returns one decoded control event per message, unmatched ones included
// (event_valid low, map_error tells an unmapped number from an unknown status).
// The block is a two-register pipeline: the message is captured in an input
// register, decoded by compares and a 35-entry range table, and stored in the
// result register, which drives the master stream. Throughput is one message
// per cycle while the receiver keeps tready high; the decode path is the only
// logic between the two registers. While the receiver stalls, the result
// register holds and the input register still takes one more message, so
// tready drops only when both registers are full. A synchronous active-low
// reset empties both registers; payload contents are not cleared.
`include "pad_controller_midi_event_decoder_defines.svh"

module pad_controller_midi_event_decoder
    import pcmed_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // status_byte[7:0], first_data[14:8], second_data[21:15], zero pad
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // control_id[7:0], value_numerator[22:8], value_divisor_code[24:23],
    // echo_status[32:25], echo_number[39:33], echo_level[46:40], zero pad
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    // event_valid[0], event_kind[2:1], echo_valid[3], map_error[4]
    output logic [OUT_USER_W-1:0] o_m_tuser
);

    logic                  r_in_valid;
    logic [IN_DATA_W-1:0]  r_in_data;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_USER_W-1:0] r_out_user;
    logic [OUT_DATA_W-1:0] n_out_data;
    logic [OUT_USER_W-1:0] n_out_user;
    logic                  s2_load;
    logic                  s1_load;

    assign s2_load    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || s2_load;
    assign s1_load    = i_s_tvalid && o_s_tready;

    logic [7:0]        st;
    logic [6:0]        d1;
    logic [6:0]        d2;
    t_map              note_map;
    t_map              cc_map;
    logic              matched;
    logic              ok;
    logic              is_cc;
    logic [7:0]        id;
    logic [1:0]        kind;
    logic signed [14:0] num;
    logic [1:0]        div;
    logic              ev_valid;
    logic              echo_valid;
    logic              map_err;

    always_comb begin
        st       = r_in_data[7:0];
        d1       = r_in_data[14:8];
        d2       = r_in_data[21:15];
        note_map = map_note(d1);
        cc_map   = map_cc(d1);
        matched  = 1'b1;
        ok       = 1'b0;
        is_cc    = 1'b0;
        id       = '0;
        kind     = KIND_PRESS;
        num      = '0;
        div      = DIV_ONE;
        if ((st == ST_NOTE_OFF || st == ST_NOTE_ON) && d2 == 7'd0) begin
            ok   = note_map.ok;
            id   = note_map.id;
            kind = KIND_RELEASE;
        end else if (st == ST_NOTE_ON) begin
            ok   = note_map.ok;
            id   = note_map.id;
            kind = KIND_PRESS;
            if (note_map.ok && note_map.id < ID_BUTTON0) begin
                num = {8'd0, d2};
                div = DIV_7BIT;
            end
        end else if (st == ST_POLY_AT) begin
            ok   = note_map.ok;
            id   = note_map.id;
            kind = KIND_CHANGE;
            num  = {8'd0, d2};
            div  = DIV_7BIT;
        end else if (st == ST_CTRL) begin
            is_cc = 1'b1;
            ok    = cc_map.ok;
            id    = cc_map.id;
            if (d2 == 7'd0) begin
                kind = KIND_RELEASE;
            end else if (cc_map.ok && cc_map.id >= ID_KNOB0) begin
                kind = KIND_CHANGE;
                num  = {{8{d2[6]}}, d2};
            end else begin
                kind = KIND_PRESS;
            end
        end else if (st == ST_PITCH) begin
            ok   = 1'b1;
            id   = ID_SLIDER;
            kind = KIND_CHANGE;
            num  = {1'b0, d2, d1};
            div  = DIV_14BIT;
        end else begin
            matched = 1'b0;
        end

        ev_valid   = matched && ok;
        map_err    = matched && !ok;
        echo_valid = ev_valid && is_cc && id >= ID_BUTTON0 && id < ID_KNOB0;

        n_out_data = '0;
        n_out_user = '0;
        if (ev_valid) begin
            n_out_data[7:0]   = id;
            n_out_data[22:8]  = num;
            n_out_data[24:23] = div;
            n_out_user[0]     = 1'b1;
            n_out_user[2:1]   = kind;
        end
        if (echo_valid) begin
            n_out_data[32:25] = st;
            n_out_data[39:33] = d1;
            n_out_data[46:40] = (kind == KIND_PRESS) ? ECHO_LEVEL_ON : 7'd0;
            n_out_user[3]     = 1'b1;
        end
        n_out_user[4] = map_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_load) begin
                r_in_valid <= 1'b1;
            end else if (s2_load) begin
                r_in_valid <= 1'b0;
            end
            if (s2_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (s1_load) begin
            r_in_data <= i_s_tdata;
        end
        if (s2_load) begin
            r_out_data <= n_out_data;
            r_out_user <= n_out_user;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    `PCMED_ASSERT_NOW(a_err_excl, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[0], !o_m_tuser[4], "event and map error both set")
    `PCMED_ASSERT_NOW(a_echo_button, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[3], o_m_tuser[0] && o_m_tdata[7:6] == 2'b01, "echo on a non-button event")
    `PCMED_ASSERT_NOW(a_echo_level, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[3] && o_m_tuser[2:1] == KIND_PRESS, o_m_tdata[46:40] == ECHO_LEVEL_ON, "press echo level wrong")
    `PCMED_ASSERT_NEXT(a_move, i_clk, i_rst_n, s2_load, o_m_tvalid, "decoded item not presented")

endmodule
